/* hdl/dfsc_pkg.sv */
// ----------------------------------------------------------------------------
// dfsc_pkg
// Shared types, constants and the stepper table of the floppy switch
// controller.
// ----------------------------------------------------------------------------
package dfsc_pkg;

   // Disk geometry and head limits
   localparam int TRACK_BYTES    = 8192;
   localparam int MAX_HALF_TRACK = 68;
   localparam int DISK_TRACKS    = 70;
   localparam int DRIVE_BYTES    = DISK_TRACKS * TRACK_BYTES;
   localparam int MEM_DEPTH      = 2 * DRIVE_BYTES;
   localparam int ADDR_W         = $clog2(MEM_DEPTH);

   // Field and state widths
   localparam int POS_W   = 13;
   localparam int HT_W    = 7;
   localparam int TRACK_W = HT_W - 1;
   localparam int PHASE_W = 4;
   localparam int DATA_W  = 8;
   localparam int LATCH_ARM_BIT = 7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Request codes
   typedef enum logic [1:0] {
      REQ_BUS_READ  = 2'd0,
      REQ_BUS_WRITE = 2'd1,
      REQ_LOAD      = 2'd2,
      REQ_NONE      = 2'd3
   } req_code_type;

   // Soft switch numbers
   localparam logic [3:0] SW_PHASE_LO   = 4'h0;
   localparam logic [3:0] SW_PHASE_HI   = 4'h7;
   localparam logic [3:0] SW_MOTOR_OFF  = 4'h8;
   localparam logic [3:0] SW_MOTOR_ON   = 4'h9;
   localparam logic [3:0] SW_SELECT_A   = 4'hA;
   localparam logic [3:0] SW_SELECT_B   = 4'hB;
   localparam logic [3:0] SW_DATA       = 4'hC;
   localparam logic [3:0] SW_LATCH      = 4'hD;
   localparam logic [3:0] SW_READ_MODE  = 4'hE;
   localparam logic [3:0] SW_WRITE_MODE = 4'hF;

   // Drive selection codes
   localparam logic [1:0] SEL_NONE = 2'd0;
   localparam logic [1:0] SEL_A    = 2'd1;
   localparam logic [1:0] SEL_B    = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_WPROT_A         = 2'd0;
   localparam logic [1:0] CSR_WPROT_B         = 2'd1;
   localparam logic [1:0] CSR_DISK_PRESENT_A  = 2'd2;
   localparam logic [1:0] CSR_DISK_PRESENT_B  = 2'd3;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_PHASE,
      CMD_MOTOR_OFF,
      CMD_MOTOR_ON,
      CMD_SELECT_A,
      CMD_SELECT_B,
      CMD_DATA,
      CMD_LATCH,
      CMD_READ_MODE,
      CMD_WRITE_MODE
   } cmd_kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      cmd_kind_type        kind;
      logic                bus_read;
      logic                bus_write;
      logic [DATA_W-1:0]   value;
      logic [1:0]          phase_num;
      logic                phase_set;
      logic                load_ok;
      logic [ADDR_W-1:0]   load_addr;
   } cmd_type;

   // Configuration registers, index 0 for drive one
   typedef struct packed {
      logic [1:0] wprot;
      logic [1:0] disk_present;
   } csr_type;

   // Half-track step by phase bits (row) and low half-track bits (column)
   localparam int STEP_TABLE [16][8] = '{
      '{ 0,  0,  0,  0,  0,  0,  0,  0},
      '{ 0, -1, -2, -3,  0,  3,  2,  1},
      '{ 2,  1,  0, -1, -2, -3,  0,  3},
      '{ 1,  0, -1, -2, -3,  0,  3,  2},
      '{ 0,  3,  2,  1,  0, -1, -2, -3},
      '{ 0, -1,  0,  1,  0, -1,  0,  1},
      '{ 3,  2,  1,  0, -1, -2, -3,  0},
      '{ 2,  1,  0, -1, -2, -3,  0,  3},
      '{-2, -3,  0,  3,  2,  1,  0, -1},
      '{-1, -2, -3,  0,  3,  2,  1,  0},
      '{ 0,  1,  0, -1,  0,  1,  0, -1},
      '{ 0, -1, -2, -3,  0,  3,  2,  1},
      '{-3,  0,  3,  2,  1,  0, -1, -2},
      '{-2, -3,  0,  3,  2,  1,  0, -1},
      '{ 0,  3,  2,  1,  0, -1, -2, -3},
      '{ 0,  0,  0,  0,  0,  0,  0,  0}
   };

endpackage

/* hdl/dfsc_front.sv */
// ----------------------------------------------------------------------------
// dfsc_front
// Accepts request transactions and classifies them into commands.
// ----------------------------------------------------------------------------
module dfsc_front (
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [3:0]                  req_switch_addr,
   input  logic [7:0]                  req_bus_value,
   input  logic                        req_load_drive,
   input  logic [5:0]                  req_load_track,
   input  logic [12:0]                 req_load_offset,
   input  logic                        queue_full,
   output logic                        push,
   output dfsc_pkg::cmd_type           push_cmd
);
   import dfsc_pkg::*;

   logic [ADDR_W-1:0] drive_base;

   assign busy = queue_full | reset;
   assign push = start & ~busy;

   assign drive_base = req_load_drive ? ADDR_W'(DRIVE_BYTES) : '0;

   always_comb begin
      push_cmd           = '0;
      push_cmd.kind      = CMD_NOP;
      push_cmd.bus_read  = (req_code_type'(req_type) == REQ_BUS_READ);
      push_cmd.bus_write = (req_code_type'(req_type) == REQ_BUS_WRITE);
      push_cmd.value     = req_bus_value;
      push_cmd.phase_num = req_switch_addr[2:1];
      push_cmd.phase_set = req_switch_addr[0];
      push_cmd.load_ok   = (ADDR_W'(req_load_track) < ADDR_W'(DISK_TRACKS)) &&
                           (ADDR_W'(req_load_offset) < ADDR_W'(TRACK_BYTES));
      push_cmd.load_addr = drive_base
                         + ADDR_W'(req_load_track) * ADDR_W'(TRACK_BYTES)
                         + ADDR_W'(req_load_offset);
      unique case (req_code_type'(req_type)) inside
         REQ_LOAD: begin
            push_cmd.kind = CMD_LOAD;
         end
         REQ_BUS_READ, REQ_BUS_WRITE: begin
            unique case (req_switch_addr) inside
               [SW_PHASE_LO:SW_PHASE_HI]: push_cmd.kind = CMD_PHASE;
               SW_MOTOR_OFF:              push_cmd.kind = CMD_MOTOR_OFF;
               SW_MOTOR_ON:               push_cmd.kind = CMD_MOTOR_ON;
               SW_SELECT_A:               push_cmd.kind = CMD_SELECT_A;
               SW_SELECT_B:               push_cmd.kind = CMD_SELECT_B;
               SW_DATA:                   push_cmd.kind = CMD_DATA;
               SW_LATCH:                  push_cmd.kind = CMD_LATCH;
               SW_READ_MODE:              push_cmd.kind = CMD_READ_MODE;
               SW_WRITE_MODE:             push_cmd.kind = CMD_WRITE_MODE;
               default:                   push_cmd.kind = CMD_NOP;
            endcase
         end
         default: begin
            push_cmd.kind = CMD_NOP;
         end
      endcase
   end

endmodule

/* hdl/dfsc_queue.sv */
// ----------------------------------------------------------------------------
// dfsc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module dfsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dfsc_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output dfsc_pkg::cmd_type    head_cmd
);
   import dfsc_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/dfsc_back.sv */
// ----------------------------------------------------------------------------
// dfsc_back
// Carries out commands: drive state, head stepping and disk memory access.
// ----------------------------------------------------------------------------
module dfsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dfsc_pkg::csr_type    csr,
   input  logic                 cmd_valid,
   input  dfsc_pkg::cmd_type    cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_read_data
);
   import dfsc_pkg::*;

   logic [PHASE_W-1:0] phase_ff [2];
   logic [PHASE_W-1:0] phase_in [2];
   logic [HT_W-1:0]    ht_ff    [2];
   logic [HT_W-1:0]    ht_in    [2];
   logic [POS_W-1:0]   pos_ff   [2];
   logic [POS_W-1:0]   pos_in   [2];
   logic [1:0]         motor_ff, motor_in;
   logic [1:0]         wmode_ff, wmode_in;
   logic [DATA_W-1:0]  latch_ff [2];
   logic [DATA_W-1:0]  latch_in [2];
   logic [1:0]         sel_ff, sel_in;

   logic [DATA_W-1:0]  disk_mem_ff [MEM_DEPTH];
   logic [DATA_W-1:0]  mem_q_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               use_mem_ff, use_mem_in;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic [DATA_W-1:0]  mem_wdata;

   logic               d, sel_idx, has_sel;
   logic [PHASE_W-1:0] ph_new;
   logic signed [3:0]  delta;
   logic signed [HT_W+1:0] ht_sum;
   logic [TRACK_W-1:0] track;
   logic               in_store;
   logic [ADDR_W-1:0]  head_addr;
   logic [POS_W:0]     pos_inc;
   logic [POS_W-1:0]   pos_adv;

   assign pop     = cmd_valid;
   assign d       = (sel_ff == SEL_B);
   assign sel_idx = (sel_ff == SEL_B);
   assign has_sel = (sel_ff == SEL_A) || (sel_ff == SEL_B);

   // Head address of the acting drive
   assign track     = ht_ff[d][HT_W-1:1];
   assign in_store  = (ADDR_W'(track) < ADDR_W'(DISK_TRACKS));
   assign head_addr = (d ? ADDR_W'(DRIVE_BYTES) : '0)
                    + ADDR_W'(track) * ADDR_W'(TRACK_BYTES)
                    + ADDR_W'(pos_ff[d]);
   assign pos_inc   = {1'b0, pos_ff[d]} + 1'b1;
   assign pos_adv   = (pos_inc >= (POS_W+1)'(TRACK_BYTES)) ? '0 : pos_inc[POS_W-1:0];

   // Phase update and stepper delta
   always_comb begin
      if (cmd.phase_set) begin
         ph_new = phase_ff[d] | (PHASE_W'(1) << cmd.phase_num);
      end else begin
         ph_new = phase_ff[d] & ~(PHASE_W'(1) << cmd.phase_num);
      end
      delta  = 4'(STEP_TABLE[ph_new][ht_ff[d][2:0]]);
      ht_sum = $signed({2'b00, ht_ff[d]}) + {{(HT_W-2){delta[3]}}, delta};
   end

   always_comb begin
      phase_in     = phase_ff;
      ht_in        = ht_ff;
      pos_in       = pos_ff;
      motor_in     = motor_ff;
      wmode_in     = wmode_ff;
      latch_in     = latch_ff;
      sel_in       = sel_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = head_addr;
      mem_wdata    = latch_ff[d];
      rsp_valid_in = cmd_valid;
      use_mem_in   = 1'b0;
      if (cmd_valid) begin
         unique case (cmd.kind)
            CMD_LOAD: begin
               mem_we    = cmd.load_ok;
               mem_addr  = cmd.load_addr;
               mem_wdata = cmd.value;
            end
            CMD_PHASE: begin
               phase_in[d] = ph_new;
               if (motor_ff[d]) begin
                  if (ht_sum > $signed((HT_W+2)'(MAX_HALF_TRACK))) begin
                     ht_in[d] = HT_W'(MAX_HALF_TRACK);
                  end else if (ht_sum[HT_W+1]) begin
                     ht_in[d] = '0;
                  end else begin
                     ht_in[d] = ht_sum[HT_W-1:0];
                  end
                  if (delta != 4'sd0) begin
                     pos_in[d] = '0;
                  end
               end
            end
            CMD_MOTOR_OFF: begin
               motor_in = '0;
            end
            CMD_MOTOR_ON: begin
               if (has_sel) begin
                  motor_in[sel_idx] = 1'b1;
               end
            end
            CMD_SELECT_A: begin
               sel_in = SEL_A;
            end
            CMD_SELECT_B: begin
               sel_in = SEL_B;
            end
            CMD_DATA: begin
               if (csr.disk_present[d]) begin
                  if (!wmode_ff[d] || csr.wprot[d]) begin
                     mem_re     = in_store;
                     use_mem_in = in_store & cmd.bus_read;
                     pos_in[d]  = pos_adv;
                  end else if (latch_ff[d][LATCH_ARM_BIT]) begin
                     mem_we    = in_store;
                     pos_in[d] = pos_adv;
                  end
               end
            end
            CMD_LATCH: begin
               if (wmode_ff[d]) begin
                  latch_in[d] = cmd.bus_write ? cmd.value : '0;
               end
            end
            CMD_READ_MODE: begin
               if (has_sel) begin
                  wmode_in[sel_idx] = 1'b0;
               end
            end
            CMD_WRITE_MODE: begin
               if (has_sel) begin
                  wmode_in[sel_idx] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '{default: '0};
         ht_ff        <= '{default: '0};
         pos_ff       <= '{default: '0};
         latch_ff     <= '{default: '0};
         motor_ff     <= '0;
         wmode_ff     <= '0;
         sel_ff       <= SEL_NONE;
         rsp_valid_ff <= 1'b0;
         use_mem_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ht_ff        <= ht_in;
         pos_ff       <= pos_in;
         latch_ff     <= latch_in;
         motor_ff     <= motor_in;
         wmode_ff     <= wmode_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         use_mem_ff   <= use_mem_in;
      end
   end

   // Disk nibble memory, single port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         disk_mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= disk_mem_ff[mem_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = use_mem_ff ? mem_q_ff : '0;

endmodule

/* hdl/floppy_drive_switch_controller_top.sv */
// ----------------------------------------------------------------------------
// floppy_drive_switch_controller_top
// Two-drive floppy soft switch controller with per-drive disk memory.
// ----------------------------------------------------------------------------
// A request transaction is taken on any edge with start high and busy low,
// one per cycle. Every transaction produces exactly one result: rsp_valid
// comes from the result register, which follows the command queue
// register, and stays high for one cycle, the strobe cycle, in which the
// result is taken; rsp_read_data carries the disk byte for a bus read of
// the data switch, zero otherwise. The result register is fed by the
// registered read port of the disk memory; the back end retires one
// command per cycle, so busy is only high during reset. There is no result
// backpressure: capture the result in the strobe cycle. Disk memory comes
// up with undefined content and has no clearing pass; load every byte
// before it is read. Write the configuration registers only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module floppy_drive_switch_controller_top (
   input  logic         clock,
   input  logic         reset,

   // Request transactions
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_type,
   input  logic [3:0]   req_switch_addr,
   input  logic [7:0]   req_bus_value,
   input  logic         req_load_drive,
   input  logic [5:0]   req_load_track,
   input  logic [12:0]  req_load_offset,

   // Result transactions
   output logic         rsp_valid,
   output logic [7:0]   rsp_read_data,

   // Configuration writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic         csr_wdata
);
   import dfsc_pkg::*;

   csr_type  csr_ff, csr_in;
   logic     queue_full;
   logic     push;
   cmd_type  push_cmd;
   logic     head_valid;
   cmd_type  head_cmd;
   logic     pop;

   // Configuration registers: always ready, one bit per register
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WPROT_A:         csr_in.wprot[0]        = csr_wdata;
            CSR_WPROT_B:         csr_in.wprot[1]        = csr_wdata;
            CSR_DISK_PRESENT_A:  csr_in.disk_present[0] = csr_wdata;
            CSR_DISK_PRESENT_B:  csr_in.disk_present[1] = csr_wdata;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.wprot        <= 2'b11;
         csr_ff.disk_present <= 2'b00;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front: accept and classify each transaction
   dfsc_front u_front (
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_switch_addr (req_switch_addr),
      .req_bus_value   (req_bus_value),
      .req_load_drive  (req_load_drive),
      .req_load_track  (req_load_track),
      .req_load_offset (req_load_offset),
      .queue_full      (queue_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   // Hold classified commands until the back end takes them
   dfsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: update drive state, access disk memory, drive the result
   dfsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .cmd_valid     (head_valid),
      .cmd           (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data)
   );

endmodule

/* hdl/dfsc_checker.sv */
// ----------------------------------------------------------------------------
// dfsc_checker
// Port-level checks of transaction ordering and result content.
// ----------------------------------------------------------------------------
module dfsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic [7:0]  rsp_read_data
);
   import dfsc_pkg::*;

   // Every accepted transaction yields a result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   // No result without an accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without accepted transaction");

   // Data is zero outside a result cycle
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (rsp_read_data == 8'd0))
      else $error("read data nonzero outside result");

   // A nonzero byte answers only a bus read
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_read_data != 8'd0) |-> $past(req_code_type'(req_type) == REQ_BUS_READ, 2))
      else $error("nonzero data for non-read transaction");

endmodule

bind floppy_drive_switch_controller_top dfsc_checker u_checker (.*);

/* test/tb_floppy_drive_switch_controller_top.sv */
// ----------------------------------------------------------------------------
// tb_floppy_drive_switch_controller_top
// Self-checking bench for the two-drive floppy soft switch controller.
// ----------------------------------------------------------------------------
// A planner builds request transactions phase by phase. It keeps its own copy
// of the drive state, so it can put a load in front of any read that would
// otherwise hit unwritten disk memory. A clocked driver feeds them to the DUT
// with random sender gaps. On every accepted transaction a predictor advances
// the checker's drive state and queues the expected read byte. A clocked
// monitor compares each result strobe against that queue. Register writes
// happen only once the DUT has drained, with several write-protect and
// disk-present settings, all-zero and all-one among them.
// ----------------------------------------------------------------------------
module tb_floppy_drive_switch_controller_top;
   import dfsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_COUNT    = 7;
   localparam int RANDOM_ITEMS   = 135;
   localparam int MAX_REPORTS    = 10;

   // Register setting per phase, bits {present_b, present_a, protect_b, protect_a}
   localparam logic [3:0] PHASE_CFG [PHASE_COUNT] = '{
      4'b1110, 4'b1100, 4'b1111, 4'b0110, 4'b1001, 4'b0000, 4'b1100
   };
   // Percentage of cycles in which the sender holds off, per phase
   localparam int PHASE_IDLE [PHASE_COUNT] = '{0, 0, 70, 6, 30, 70, 6};

   // Half-track step by phase bits (row) and low half-track bits (column)
   localparam int HEAD_STEP [16][8] = '{
      '{ 0,  0,  0,  0,  0,  0,  0,  0},
      '{ 0, -1, -2, -3,  0,  3,  2,  1},
      '{ 2,  1,  0, -1, -2, -3,  0,  3},
      '{ 1,  0, -1, -2, -3,  0,  3,  2},
      '{ 0,  3,  2,  1,  0, -1, -2, -3},
      '{ 0, -1,  0,  1,  0, -1,  0,  1},
      '{ 3,  2,  1,  0, -1, -2, -3,  0},
      '{ 2,  1,  0, -1, -2, -3,  0,  3},
      '{-2, -3,  0,  3,  2,  1,  0, -1},
      '{-1, -2, -3,  0,  3,  2,  1,  0},
      '{ 0,  1,  0, -1,  0,  1,  0, -1},
      '{ 0, -1, -2, -3,  0,  3,  2,  1},
      '{-3,  0,  3,  2,  1,  0, -1, -2},
      '{-2, -3,  0,  3,  2,  1,  0, -1},
      '{ 0,  3,  2,  1,  0, -1, -2, -3},
      '{ 0,  0,  0,  0,  0,  0,  0,  0}
   };

   // One request transaction
   typedef struct packed {
      req_code_type         kind;
      logic [3:0]           sw;
      logic [DATA_W-1:0]    val;
      logic                 drv;
      logic [5:0]           trk;
      logic [POS_W-1:0]     off;
   } switch_req_type;

   // Per-drive control state plus the configuration registers, index 0 is drive one
   typedef struct packed {
      logic [1:0][PHASE_W-1:0] phase;
      logic [1:0][HT_W-1:0]    ht;
      logic [1:0][POS_W-1:0]   pos;
      logic [1:0]              motor;
      logic [1:0]              wmode;
      logic [1:0][DATA_W-1:0]  latch;
      logic [1:0]              sel;
      logic [1:0]              wp;
      logic [1:0]              present;
   } drive_ctl_type;

   typedef struct packed {
      int unsigned       seq;
      logic [DATA_W-1:0] data;
   } read_expect_type;

   // DUT connections; every input starts at a known value
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        busy;
   logic [1:0]  req_type        = '0;
   logic [3:0]  req_switch_addr = '0;
   logic [7:0]  req_bus_value   = '0;
   logic        req_load_drive  = 1'b0;
   logic [5:0]  req_load_track  = '0;
   logic [12:0] req_load_offset = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index       = '0;
   logic        csr_wdata       = 1'b0;

   // Planner side
   switch_req_type  switch_cmd_q [$];
   drive_ctl_type   plan_ctl;
   bit              plan_written [int];
   int unsigned     planned_cnt = 0;
   int              phase_items = 0;
   int              idle_pct    = 0;
   int              csr_writes  = 0;

   // Checker side
   drive_ctl_type   drive_ctl;
   logic [7:0]      disk_image [int];
   read_expect_type read_data_q [$];
   read_expect_type expect_item;
   read_expect_type got_item;
   switch_req_type  sent_req;
   int unsigned     accepted_cnt = 0;
   int              fail_count   = 0;
   int              disk_reads   = 0;
   int              disk_stores  = 0;
   int              deepest_ht   = 0;
   int              stall_cycles = 0;
   logic            hit_rd, hit_wr;
   int              hit_addr;
   logic [7:0]      hit_byte;

   floppy_drive_switch_controller_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_switch_addr (req_switch_addr),
      .req_bus_value   (req_bus_value),
      .req_load_drive  (req_load_drive),
      .req_load_track  (req_load_track),
      .req_load_offset (req_load_offset),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Drive state model
   // ------------------------------------------------------------------------
   function automatic drive_ctl_type ctl_after_reset();
      drive_ctl_type s;
      s    = '0;
      s.wp = 2'b11;
      return s;
   endfunction

   function automatic void apply_csr(inout drive_ctl_type s, input logic [1:0] idx,
                                     input logic v);
      case (idx)
         CSR_WPROT_A:         s.wp[0]      = v;
         CSR_WPROT_B:         s.wp[1]      = v;
         CSR_DISK_PRESENT_A:  s.present[0] = v;
         default:             s.present[1] = v;
      endcase
   endfunction

   // Advance the drive state by one transaction and report the disk memory
   // access it makes: a byte read at addr (rd) or a byte store (wr).
   function automatic void switch_effect(inout drive_ctl_type s, input switch_req_type r,
                                         output logic rd, output logic wr,
                                         output int addr, output logic [7:0] wbyte);
      int d, delta, nht, trk;
      logic [POS_W-1:0] adv;
      rd    = 1'b0;
      wr    = 1'b0;
      addr  = 0;
      wbyte = '0;
      if (r.kind == REQ_LOAD) begin
         if (r.trk < DISK_TRACKS && r.off < TRACK_BYTES) begin
            wr    = 1'b1;
            addr  = int'(r.drv) * DRIVE_BYTES + int'(r.trk) * TRACK_BYTES + int'(r.off);
            wbyte = r.val;
         end
         return;
      end
      if (r.kind == REQ_NONE)
         return;
      // With nothing selected, drive one acts
      d = (s.sel == SEL_B) ? 1 : 0;
      if (r.sw <= SW_PHASE_HI) begin
         s.phase[d][r.sw[2:1]] = r.sw[0];
         if (s.motor[d]) begin
            delta = HEAD_STEP[s.phase[d]][s.ht[d][2:0]];
            nht   = int'(s.ht[d]) + delta;
            if (nht > MAX_HALF_TRACK)
               nht = MAX_HALF_TRACK;
            if (nht < 0)
               nht = 0;
            s.ht[d] = HT_W'(nht);
            // Any real movement rehomes the byte position
            if (delta != 0)
               s.pos[d] = '0;
         end
         return;
      end
      case (r.sw)
         SW_MOTOR_OFF: s.motor = '0;
         SW_MOTOR_ON: begin
            if (s.sel == SEL_A || s.sel == SEL_B)
               s.motor[s.sel == SEL_B] = 1'b1;
         end
         SW_SELECT_A: s.sel = SEL_A;
         SW_SELECT_B: s.sel = SEL_B;
         SW_DATA: begin
            if (s.present[d]) begin
               trk  = int'(s.ht[d]) / 2;
               addr = d * DRIVE_BYTES + trk * TRACK_BYTES + int'(s.pos[d]);
               adv  = (int'(s.pos[d]) + 1 >= TRACK_BYTES) ? '0 : s.pos[d] + 1'b1;
               if (!s.wmode[d] || s.wp[d]) begin
                  rd       = (trk < DISK_TRACKS);
                  s.pos[d] = adv;
               end else if (s.latch[d][LATCH_ARM_BIT]) begin
                  wr       = (trk < DISK_TRACKS);
                  wbyte    = s.latch[d];
                  s.pos[d] = adv;
               end
            end
         end
         SW_LATCH: begin
            if (s.wmode[d])
               s.latch[d] = (r.kind == REQ_BUS_WRITE) ? r.val : '0;
         end
         SW_READ_MODE: begin
            if (s.sel == SEL_A || s.sel == SEL_B)
               s.wmode[s.sel == SEL_B] = 1'b0;
         end
         SW_WRITE_MODE: begin
            if (s.sel == SEL_A || s.sel == SEL_B)
               s.wmode[s.sel == SEL_B] = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus planning
   // ------------------------------------------------------------------------
   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic req_code_type any_bus();
      return $urandom_range(1) ? REQ_BUS_WRITE : REQ_BUS_READ;
   endfunction

   // Fill the load fields at random even where the DUT ignores them
   function automatic switch_req_type make_req(req_code_type k, logic [3:0] sw,
                                               logic [7:0] v);
      switch_req_type r;
      r.kind = k;
      r.sw   = sw;
      r.val  = v;
      r.drv  = 1'($urandom_range(1));
      r.trk  = 6'($urandom_range(63));
      r.off  = POS_W'($urandom_range(TRACK_BYTES - 1));
      return r;
   endfunction

   function automatic switch_req_type load_req(logic drv, logic [5:0] trk,
                                               logic [POS_W-1:0] off, logic [7:0] v);
      switch_req_type r;
      r     = make_req(REQ_LOAD, 4'($urandom_range(15)), v);
      r.drv = drv;
      r.trk = trk;
      r.off = off;
      return r;
   endfunction

   // Queue a transaction. When it would read a byte never written, queue a
   // load of that byte first so the DUT never reads undefined memory.
   function automatic void schedule(switch_req_type r);
      drive_ctl_type trial;
      logic rd, wr;
      int addr;
      logic [7:0] wb;
      trial = plan_ctl;
      switch_effect(trial, r, rd, wr, addr, wb);
      if (rd && !plan_written.exists(addr)) begin
         switch_cmd_q.push_back(load_req(1'(addr / DRIVE_BYTES),
                                         6'((addr % DRIVE_BYTES) / TRACK_BYTES),
                                         POS_W'(addr % TRACK_BYTES), any_byte()));
         plan_written[addr] = 1'b1;
         planned_cnt++;
         phase_items++;
      end
      if (wr)
         plan_written[addr] = 1'b1;
      plan_ctl = trial;
      switch_cmd_q.push_back(r);
      planned_cnt++;
      if (r.kind != REQ_NONE)
         phase_items++;
   endfunction

   // Field extremes, every switch except phase switch 6, stepping, latch arming and protection
   task automatic directed_items();
      schedule(load_req(1'b0, 6'd0, '0, 8'hFF));
      schedule(load_req(1'b1, 6'd63, POS_W'(TRACK_BYTES - 1), 8'h00));
      schedule(make_req(REQ_NONE, 4'hF, 8'hFF));
      schedule(make_req(REQ_BUS_READ, SW_DATA, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, SW_SELECT_A, 8'h00));
      schedule(make_req(REQ_BUS_READ, SW_MOTOR_ON, 8'hFF));
      schedule(make_req(REQ_BUS_WRITE, 4'h1, 8'hFF));
      schedule(make_req(REQ_BUS_WRITE, 4'h3, 8'h55));
      schedule(make_req(REQ_BUS_WRITE, 4'h0, 8'hAA));
      schedule(make_req(REQ_BUS_WRITE, 4'h5, 8'h01));
      schedule(make_req(REQ_BUS_WRITE, 4'h2, 8'h80));
      schedule(make_req(REQ_BUS_READ, SW_WRITE_MODE, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, SW_LATCH, 8'hC5));
      schedule(make_req(REQ_BUS_READ, SW_DATA, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, SW_LATCH, 8'h45));
      schedule(make_req(REQ_BUS_READ, SW_DATA, 8'h00));
      schedule(make_req(REQ_BUS_READ, SW_LATCH, 8'hFF));
      schedule(make_req(REQ_BUS_READ, SW_READ_MODE, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, 4'h4, 8'h7F));
      schedule(make_req(REQ_BUS_READ, SW_DATA, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, SW_MOTOR_OFF, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, SW_SELECT_B, 8'hFF));
      schedule(make_req(REQ_BUS_READ, SW_MOTOR_ON, 8'h00));
      schedule(make_req(REQ_BUS_READ, SW_WRITE_MODE, 8'h00));
      schedule(make_req(REQ_BUS_READ, SW_DATA, 8'h00));
      schedule(make_req(REQ_BUS_WRITE, 4'h7, 8'hFF));
   endtask

   // Mostly well-formed bursts with random content, the rest noise
   task automatic random_items(int target);
      int pick, k, nk, n;
      bit up;
      phase_items = 0;
      while (phase_items < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // Seek: select, mostly spin up, then walk the magnets one phase at a time
            schedule(make_req(any_bus(), $urandom_range(1) ? SW_SELECT_B : SW_SELECT_A,
                              any_byte()));
            if ($urandom_range(4) != 0)
               schedule(make_req(any_bus(), SW_MOTOR_ON, any_byte()));
            k  = $urandom_range(3);
            up = 1'($urandom_range(1));
            n  = ($urandom_range(3) == 0) ? $urandom_range(40, 70) : $urandom_range(2, 20);
            repeat (n) begin
               nk = up ? (k + 1) % 4 : (k + 3) % 4;
               schedule(make_req(any_bus(), 4'(2 * nk + 1), any_byte()));
               schedule(make_req(any_bus(), 4'(2 * k), any_byte()));
               k = nk;
            end
         end else if (pick < 45) begin
            // Read run
            if ($urandom_range(1))
               schedule(make_req(any_bus(), SW_READ_MODE, any_byte()));
            repeat ($urandom_range(1, 12))
               schedule(make_req($urandom_range(4) ? REQ_BUS_READ : REQ_BUS_WRITE,
                                 SW_DATA, any_byte()));
         end else if (pick < 62) begin
            // Write run: arm the latch, store, repeat
            if ($urandom_range(1))
               schedule(make_req(any_bus(), $urandom_range(1) ? SW_SELECT_B : SW_SELECT_A,
                                 any_byte()));
            schedule(make_req(any_bus(), SW_WRITE_MODE, any_byte()));
            repeat ($urandom_range(1, 8)) begin
               schedule(make_req($urandom_range(7) ? REQ_BUS_WRITE : REQ_BUS_READ, SW_LATCH,
                                 $urandom_range(3) ? (any_byte() | 8'h80) : any_byte()));
               schedule(make_req(any_bus(), SW_DATA, any_byte()));
            end
            if ($urandom_range(3))
               schedule(make_req(any_bus(), SW_READ_MODE, any_byte()));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4))
               schedule(load_req(1'($urandom_range(1)), 6'($urandom_range(63)),
                                 $urandom_range(1) ? POS_W'($urandom_range(31))
                                                   : POS_W'($urandom_range(TRACK_BYTES - 1)),
                                 any_byte()));
         end else begin
            schedule(make_req(req_code_type'($urandom_range(3)), 4'($urandom_range(15)),
                              any_byte()));
         end
      end
   endtask

   // Write one register; the DUT is idle whenever this is called
   task automatic write_csr(input logic [1:0] idx, input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(plan_ctl, idx, v);
      csr_writes++;
   endtask

   // Wait until every planned transaction is accepted and answered
   task automatic wait_drained();
      do @(posedge clock); while (accepted_cnt != planned_cnt || read_data_q.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Sequencer: reset once, then one register setting per phase
   // ------------------------------------------------------------------------
   initial begin
      plan_ctl = ctl_after_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // Registers change only with nothing in flight
         if (ph > 0)
            wait_drained();
         write_csr(CSR_WPROT_A, PHASE_CFG[ph][0]);
         write_csr(CSR_WPROT_B, PHASE_CFG[ph][1]);
         write_csr(CSR_DISK_PRESENT_A, PHASE_CFG[ph][2]);
         write_csr(CSR_DISK_PRESENT_B, PHASE_CFG[ph][3]);
         idle_pct = PHASE_IDLE[ph];
         if (ph == 0)
            directed_items();
         else
            random_items(RANDOM_ITEMS);
      end
      wait_drained();
      // Allow for a stray late strobe to show up
      repeat (8) @(posedge clock);
      $display("Covered %0d transactions over %0d register settings (%0d register writes).",
               accepted_cnt, PHASE_COUNT, csr_writes);
      $display("Disk bytes read back: %0d, stored by the head: %0d, deepest half-track: %0d.",
               disk_reads, disk_stores, deepest_ht);
      if (fail_count == 0 && read_data_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: predict on acceptance, then present the next transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         drive_ctl  = ctl_after_reset();
      end else begin
         if (csr_valid && csr_ready)
            apply_csr(drive_ctl, csr_index, csr_wdata);
         if (start && !busy) begin
            switch_effect(drive_ctl, sent_req, hit_rd, hit_wr, hit_addr, hit_byte);
            expect_item.seq  = accepted_cnt;
            expect_item.data = (sent_req.kind == REQ_BUS_READ && hit_rd) ?
                               disk_image[hit_addr] : '0;
            if (sent_req.kind == REQ_BUS_READ && hit_rd)
               disk_reads++;
            if (hit_wr) begin
               disk_image[hit_addr] = hit_byte;
               if (sent_req.kind != REQ_LOAD)
                  disk_stores++;
            end
            for (int d = 0; d < 2; d++)
               if (int'(drive_ctl.ht[d]) > deepest_ht)
                  deepest_ht = int'(drive_ctl.ht[d]);
            read_data_q.push_back(expect_item);
            accepted_cnt++;
         end
         // Hold the current transaction while busy; otherwise advance or idle
         if (!(start && busy)) begin
            if (switch_cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               sent_req         = switch_cmd_q.pop_front();
               start           <= 1'b1;
               req_type        <= sent_req.kind;
               req_switch_addr <= sent_req.sw;
               req_bus_value   <= sent_req.val;
               req_load_drive  <= sent_req.drv;
               req_load_track  <= sent_req.trk;
               req_load_offset <= sent_req.off;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: take each result strobe and compare with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (read_data_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result read_data=%02h with nothing pending",
                        rsp_read_data);
         end else begin
            got_item = read_data_q.pop_front();
            if (rsp_read_data !== got_item.data) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("transaction %0d: read_data expected %02h, got %02h",
                           got_item.seq, got_item.data, rsp_read_data);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: drop the run when nothing moves for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

/* filelist.f */
hdl/dfsc_pkg.sv
hdl/dfsc_front.sv
hdl/dfsc_queue.sv
hdl/dfsc_back.sv
hdl/floppy_drive_switch_controller_top.sv
hdl/dfsc_checker.sv
test/tb_floppy_drive_switch_controller_top.sv
